// ===== sv/idr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// idr_pkg: shared types and constants of the directory record parser
// Result kind codes, record layout offsets and the per-byte result bundle.
// ----------------------------------------------------------------------------
package idr_pkg;

	// result kinds
	localparam logic [1:0] KIND_CHAR    = 2'd0;
	localparam logic [1:0] KIND_SUMMARY = 2'd1;
	localparam logic [1:0] KIND_END     = 2'd2;
	localparam logic [1:0] KIND_STOP    = 2'd3;

	// directory record layout (byte positions within a record)
	localparam logic [7:0] REC_LBA_POS   = 8'd2;
	localparam logic [7:0] REC_LBA_LAST  = 8'd5;
	localparam logic [7:0] REC_SIZE_POS  = 8'd10;
	localparam logic [7:0] REC_SIZE_LAST = 8'd13;
	localparam logic [7:0] REC_FLAGS_POS = 8'd25;
	localparam logic [7:0] REC_IDLEN_POS = 8'd32;
	localparam logic [7:0] HDR_LEN       = 8'd33;
	localparam logic [7:0] MIN_REC       = 8'd34;

	localparam logic [7:0] CHAR_SEMI     = 8'h3B;
	localparam logic [7:0] DOT_MAX       = 8'h01;

	// bundle queue depth
	localparam int QDEPTH = 2;

	// all results caused by one input item
	typedef struct packed {
		logic        has_char;
		logic [7:0]  name_char;
		logic        has_sum;
		logic [31:0] extent_lba;
		logic [31:0] file_size;
		logic        is_dir;
		logic [7:0]  name_len;
		logic        has_tail;
		logic [1:0]  tail_kind;
	} bundle_t;

endpackage

// ===== sv/idr_byte_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// idr_byte_if: input channel of the directory record parser
// One extent byte per item, valid/ready handshake.
// ----------------------------------------------------------------------------
interface idr_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;

	modport source (output valid, output data_byte, input ready);
	modport sink (input valid, input data_byte, output ready);
endinterface

// ===== sv/idr_result_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// idr_result_if: result channel of the directory record parser
// One result item per handshake: name character, summary or status.
// ----------------------------------------------------------------------------
interface idr_result_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [7:0]  name_char;
	logic [31:0] extent_lba;
	logic [31:0] file_size;
	logic        is_dir;
	logic [7:0]  name_len;
	logic        last;

	modport source (output valid, output kind, output name_char, output extent_lba,
		output file_size, output is_dir, output name_len, output last, input ready);
	modport sink (input valid, input kind, input name_char, input extent_lba,
		input file_size, input is_dir, input name_len, input last, output ready);
endinterface

// ===== sv/idr_parse.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// idr_parse: per-byte record walker
// Holds the parse state and turns each accepted byte into a result bundle.
// ----------------------------------------------------------------------------
module idr_parse
	import idr_pkg::*;
#(
	parameter int BLOCK_BYTES = 2048
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [31:0] cfg_wdata,
	input  logic        accept,
	input  logic [7:0]  data_byte,
	output logic        push,
	output bundle_t     bundle
);

	localparam int BP_W = $clog2(BLOCK_BYTES);
	localparam logic [BP_W-1:0] BP_LAST = BP_W'(BLOCK_BYTES - 1);

	logic [31:0]     extent_size_q;
	logic [31:0]     offset_q, offset_n;
	logic [BP_W-1:0] blk_pos_q, blk_pos_n;
	logic [7:0]      rec_pos_q, rec_pos_n;
	logic [7:0]      rec_len_q, rec_len_n;
	logic [7:0]      id_len_q, id_len_n;
	logic [31:0]     start_q, start_n;
	logic [31:0]     count_q, count_n;
	logic            dir_q, dir_n;
	logic [7:0]      trim_q, trim_n;
	logic            semi_q, semi_n;
	logic            supp_q, supp_n;
	logic            skip_q, skip_n;
	logic            stop_q, stop_n;

	logic            active;
	logic            stop_hit;
	logic [7:0]      pos;
	logic [7:0]      k;
	logic [7:0]      lane;
	logic            blank;
	logic [7:0]      lower;

	assign active = !stop_q && (offset_q < extent_size_q);
	assign pos    = rec_pos_q;
	assign k      = pos - HDR_LEN;
	assign blank  = (data_byte == 8'h20) || (data_byte inside {[8'h09:8'h0D]});
	assign lower  = (data_byte inside {[8'h41:8'h5A]}) ? data_byte + 8'h20 : data_byte;

	// next state and result bundle for the accepted byte
	always_comb begin
		offset_n  = offset_q;
		blk_pos_n = blk_pos_q;
		rec_pos_n = rec_pos_q;
		rec_len_n = rec_len_q;
		id_len_n  = id_len_q;
		start_n   = start_q;
		count_n   = count_q;
		dir_n     = dir_q;
		trim_n    = trim_q;
		semi_n    = semi_q;
		supp_n    = supp_q;
		skip_n    = skip_q;
		stop_n    = stop_q;
		stop_hit  = 1'b0;
		lane      = 8'd0;
		bundle    = '0;

		if (accept && active) begin
			offset_n  = offset_q + 32'd1;
			blk_pos_n = (blk_pos_q == BP_LAST) ? '0 : blk_pos_q + 1'b1;
			// skipping ends at a block boundary
			skip_n    = skip_q && (blk_pos_q != '0);

			if (skip_n) begin
				// padding byte, ignored
			end else if (rec_len_q == 8'd0) begin
				// record start: length byte
				if (data_byte == 8'd0) begin
					skip_n = 1'b1;
				end else if (({1'b0, offset_q} + {25'd0, data_byte} > {1'b0, extent_size_q})
						|| (data_byte < MIN_REC)) begin
					stop_n   = 1'b1;
					stop_hit = 1'b1;
				end else begin
					rec_len_n = data_byte;
					rec_pos_n = 8'd1;
					id_len_n  = 8'd0;
					start_n   = 32'd0;
					count_n   = 32'd0;
					dir_n     = 1'b0;
					trim_n    = 8'd0;
					semi_n    = 1'b0;
					supp_n    = 1'b0;
				end
			end else begin
				// field capture by position
				if (pos >= REC_LBA_POS && pos <= REC_LBA_LAST) begin
					lane = pos - REC_LBA_POS;
					start_n[{lane[1:0], 3'b000} +: 8] = start_q[{lane[1:0], 3'b000} +: 8]
						| data_byte;
				end else if (pos >= REC_SIZE_POS && pos <= REC_SIZE_LAST) begin
					lane = pos - REC_SIZE_POS;
					count_n[{lane[1:0], 3'b000} +: 8] = count_q[{lane[1:0], 3'b000} +: 8]
						| data_byte;
				end else if (pos == REC_FLAGS_POS) begin
					dir_n = data_byte[1];
				end else if (pos == REC_IDLEN_POS) begin
					id_len_n = data_byte;
					supp_n   = ({1'b0, HDR_LEN} + {1'b0, data_byte}) > {1'b0, rec_len_q};
				end else if (pos >= HDR_LEN
						&& {1'b0, pos} < ({1'b0, HDR_LEN} + {1'b0, id_len_q})
						&& !supp_q) begin
					// identifier byte
					if (id_len_q == 8'd1 && k == 8'd0 && data_byte <= DOT_MAX) begin
						supp_n = 1'b1;
					end else if (!semi_q) begin
						if (data_byte == CHAR_SEMI) begin
							semi_n = 1'b1;
						end else begin
							bundle.has_char  = 1'b1;
							bundle.name_char = lower;
							if (!blank) begin
								trim_n = k + 8'd1;
							end
						end
					end
				end

				// record end
				if (({1'b0, pos} + 9'd1) >= {1'b0, rec_len_q}) begin
					if (!supp_n) begin
						bundle.has_sum    = 1'b1;
						bundle.extent_lba = start_n;
						bundle.file_size  = count_n;
						bundle.is_dir     = dir_n;
						bundle.name_len   = trim_n;
					end
					rec_len_n = 8'd0;
					rec_pos_n = 8'd0;
				end else begin
					rec_pos_n = pos + 8'd1;
				end
			end

			// status tail
			if (stop_hit) begin
				bundle.has_tail  = 1'b1;
				bundle.tail_kind = KIND_STOP;
			end else if (offset_n == extent_size_q) begin
				bundle.has_tail  = 1'b1;
				bundle.tail_kind = KIND_END;
			end
		end
	end

	assign push = bundle.has_char || bundle.has_sum || bundle.has_tail;

	// parse state; a configuration write rearms at offset zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			extent_size_q <= 32'd0;
			offset_q      <= 32'd0;
			blk_pos_q     <= '0;
			rec_pos_q     <= 8'd0;
			rec_len_q     <= 8'd0;
			id_len_q      <= 8'd0;
			start_q       <= 32'd0;
			count_q       <= 32'd0;
			dir_q         <= 1'b0;
			trim_q        <= 8'd0;
			semi_q        <= 1'b0;
			supp_q        <= 1'b0;
			skip_q        <= 1'b0;
			stop_q        <= 1'b0;
		end else if (cfg_we) begin
			extent_size_q <= cfg_wdata;
			offset_q      <= 32'd0;
			blk_pos_q     <= '0;
			rec_pos_q     <= 8'd0;
			rec_len_q     <= 8'd0;
			id_len_q      <= 8'd0;
			start_q       <= 32'd0;
			count_q       <= 32'd0;
			dir_q         <= 1'b0;
			trim_q        <= 8'd0;
			semi_q        <= 1'b0;
			supp_q        <= 1'b0;
			skip_q        <= 1'b0;
			stop_q        <= 1'b0;
		end else begin
			offset_q      <= offset_n;
			blk_pos_q     <= blk_pos_n;
			rec_pos_q     <= rec_pos_n;
			rec_len_q     <= rec_len_n;
			id_len_q      <= id_len_n;
			start_q       <= start_n;
			count_q       <= count_n;
			dir_q         <= dir_n;
			trim_q        <= trim_n;
			semi_q        <= semi_n;
			supp_q        <= supp_n;
			skip_q        <= skip_n;
			stop_q        <= stop_n;
		end
	end

endmodule

// ===== sv/idr_out_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// idr_out_queue: result bundle queue and serializer
// Buffers per-byte bundles and sends their results one item at a time.
// ----------------------------------------------------------------------------
module idr_out_queue
	import idr_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  bundle_t             push_data,
	output logic                full,
	idr_result_if.source        out_ch
);

	localparam int PTR_W = $clog2(QDEPTH);
	localparam int CNT_W = $clog2(QDEPTH + 1);

	bundle_t          ent_q [QDEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic [2:0]       done_q;

	bundle_t    head;
	logic [2:0] mask;
	logic [2:0] rem;
	logic [2:0] sel;
	logic       fire;
	logic       pop;

	assign head = ent_q[rd_ptr_q];
	assign mask = {head.has_tail, head.has_sum, head.has_char};
	assign rem  = mask & ~done_q;
	assign full = (cnt_q == CNT_W'(QDEPTH));

	// pick the first result not yet delivered
	always_comb begin
		if (rem[0]) begin
			sel = 3'b001;
		end else if (rem[1]) begin
			sel = 3'b010;
		end else begin
			sel = 3'b100;
		end
	end

	assign fire = out_ch.valid && out_ch.ready;
	assign pop  = fire && out_ch.last;

	// result item fields
	always_comb begin
		out_ch.valid      = (cnt_q != '0);
		out_ch.last       = ((rem & ~sel) == 3'b000);
		out_ch.kind       = KIND_CHAR;
		out_ch.name_char  = 8'd0;
		out_ch.extent_lba = 32'd0;
		out_ch.file_size  = 32'd0;
		out_ch.is_dir     = 1'b0;
		out_ch.name_len   = 8'd0;
		if (sel[0]) begin
			out_ch.name_char = head.name_char;
		end else if (sel[1]) begin
			out_ch.kind       = KIND_SUMMARY;
			out_ch.extent_lba = head.extent_lba;
			out_ch.file_size  = head.file_size;
			out_ch.is_dir     = head.is_dir;
			out_ch.name_len   = head.name_len;
		end else begin
			out_ch.kind = head.tail_kind;
		end
	end

	// bundle storage
	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= push_data;
		end
	end

	// pointers, fill count and delivered mask of the head
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
			done_q   <= 3'b000;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
				done_q   <= 3'b000;
			end else if (fire) begin
				done_q <= done_q | sel;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// ===== sv/iso9660_dir_record_parser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iso9660_dir_record_parser: streaming directory extent parser
// Walks directory records byte by byte and reports names and entry summaries.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one extent byte per item; out_ch carries result items:
//   lowercased name characters, an entry summary per record (none for dot
//   entries or oversized identifiers), an extent-end item, or a stop item on
//   a malformed record. last marks the final result caused by one byte.
//   Write extent_size (extent_size_we/extent_size_wdata) while idle to rearm
//   the parser at offset zero. Each accepted byte is parsed in the cycle it
//   is taken; its results are registered into a two-entry bundle queue and
//   leave from the cycle after, one per cycle while out_ch.ready is high. A
//   byte is accepted every cycle while the queue has room; a byte that causes
//   several results sends them one after another. A stalled receiver fills
//   the queue, then in_ch.ready drops; no result is lost. Reset clears
//   extent_size to zero, so bytes give no results until it is written.
// ----------------------------------------------------------------------------
module iso9660_dir_record_parser
	import idr_pkg::*;
#(
	parameter int BLOCK_BYTES = 2048
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         extent_size_we,
	input  logic [31:0]  extent_size_wdata,
	idr_byte_if.sink     in_ch,
	idr_result_if.source out_ch
);

	logic    full;
	logic    accept;
	logic    push;
	bundle_t bundle;

	// a byte may cause up to three results; one queue slot holds them all
	assign in_ch.ready = !full;
	assign accept      = in_ch.valid && !full;

	idr_parse #(
		.BLOCK_BYTES(BLOCK_BYTES)
	) u_parse (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (extent_size_we),
		.cfg_wdata (extent_size_wdata),
		.accept    (accept),
		.data_byte (in_ch.data_byte),
		.push      (push),
		.bundle    (bundle)
	);

	idr_out_queue u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (bundle),
		.full      (full),
		.out_ch    (out_ch)
	);

endmodule

// ===== dv/idr_result_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// idr_result_checker: result predictor and scoreboard of the record parser
// Watches the extent size port and both channels. It tracks the directory
// record walk, queues the results that each accepted byte should cause, and
// compares every accepted result item with the oldest queued one.
// ----------------------------------------------------------------------------
module idr_result_checker
	import idr_pkg::*;
#(
	parameter int BLOCK_BYTES = 2048
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        extent_size_we,
	input  logic [31:0] extent_size_wdata,
	idr_byte_if         in_ch,
	idr_result_if       out_ch,
	output int          fail_count,
	output int          outstanding
);

	typedef struct {
		logic [1:0]  kind;
		logic [7:0]  name_char;
		logic [31:0] extent_lba;
		logic [31:0] file_size;
		logic        is_dir;
		logic [7:0]  name_len;
		logic        last;
	} dir_result_t;

	// results still owed by the parser, oldest first
	dir_result_t parsed_q[$];

	// own image of the parser state
	logic [31:0] extent_size;
	logic [31:0] byte_offset;
	logic [31:0] start_block;
	logic [31:0] byte_count;
	logic [7:0]  rec_pos;
	logic [7:0]  rec_len;
	logic [7:0]  id_len;
	logic [7:0]  trim_len;
	logic        dir_flag;
	logic        semi_seen;
	logic        suppressed;
	logic        skipping;
	logic        stopped;
	int          fails;

	function automatic void clear_walk();
		byte_offset = '0;
		rec_pos     = '0;
		rec_len     = '0;
		id_len      = '0;
		start_block = '0;
		byte_count  = '0;
		dir_flag    = 1'b0;
		trim_len    = '0;
		semi_seen   = 1'b0;
		suppressed  = 1'b0;
		skipping    = 1'b0;
		stopped     = 1'b0;
	endfunction

	function automatic void add_result(input logic [1:0] kind, input logic [7:0] ch,
			input logic [31:0] lba, input logic [31:0] size, input logic dir,
			input logic [7:0] len);
		dir_result_t r;
		r.kind       = kind;
		r.name_char  = ch;
		r.extent_lba = lba;
		r.file_size  = size;
		r.is_dir     = dir;
		r.name_len   = len;
		r.last       = 1'b0;
		parsed_q.insert(parsed_q.size(), r);
	endfunction

	// flag the newest queued result as the final one of its byte
	function automatic void mark_last();
		parsed_q[parsed_q.size() - 1].last = 1'b1;
	endfunction

	// one extent byte through the record walk
	task automatic walk_byte(input logic [7:0] b);
		int unsigned off;
		int          pos;
		int          k;
		int          first;
		first = parsed_q.size();
		if (stopped || byte_offset >= extent_size)
			return;
		off = byte_offset;
		byte_offset = byte_offset + 32'd1;

		// a zero length byte skips to the next block boundary
		if (skipping && (off % BLOCK_BYTES) == 0)
			skipping = 1'b0;

		if (!skipping) begin
			if (rec_len == 8'd0) begin
				// record start
				if (b == 8'd0) begin
					skipping = 1'b1;
				end else if (64'(off) + 64'(b) > 64'(extent_size) || b < MIN_REC) begin
					stopped = 1'b1;
					add_result(KIND_STOP, '0, '0, '0, 1'b0, '0);
					mark_last();
					return;
				end else begin
					rec_len     = b;
					rec_pos     = 8'd1;
					id_len      = '0;
					start_block = '0;
					byte_count  = '0;
					dir_flag    = 1'b0;
					trim_len    = '0;
					semi_seen   = 1'b0;
					suppressed  = 1'b0;
				end
			end else begin
				pos = int'(rec_pos);
				if (pos >= REC_LBA_POS && pos <= REC_LBA_LAST) begin
					start_block |= 32'(b) << (8 * (pos - REC_LBA_POS));
				end else if (pos >= REC_SIZE_POS && pos <= REC_SIZE_LAST) begin
					byte_count |= 32'(b) << (8 * (pos - REC_SIZE_POS));
				end else if (pos == REC_FLAGS_POS) begin
					dir_flag = b[1];
				end else if (pos == REC_IDLEN_POS) begin
					id_len = b;
					suppressed = (int'(HDR_LEN) + int'(b) > int'(rec_len));
				end else if (pos >= HDR_LEN && pos < int'(HDR_LEN) + int'(id_len)
						&& !suppressed) begin
					k = pos - int'(HDR_LEN);
					if (id_len == 8'd1 && k == 0 && b <= DOT_MAX) begin
						// dot entries give nothing
						suppressed = 1'b1;
					end else if (!semi_seen) begin
						if (b == CHAR_SEMI) begin
							semi_seen = 1'b1;
						end else begin
							add_result(KIND_CHAR, (b >= "A" && b <= "Z") ? b + 8'h20 : b,
								'0, '0, 1'b0, '0);
							if (!(b == 8'h20 || (b >= 8'h09 && b <= 8'h0D)))
								trim_len = 8'(k + 1);
						end
					end
				end

				// record end: summary unless suppressed
				if (pos + 1 >= int'(rec_len)) begin
					if (!suppressed)
						add_result(KIND_SUMMARY, '0, start_block, byte_count, dir_flag,
							trim_len);
					rec_len = '0;
					rec_pos = '0;
				end else begin
					rec_pos = 8'(pos + 1);
				end
			end
		end

		if (byte_offset == extent_size)
			add_result(KIND_END, '0, '0, '0, 1'b0, '0);
		if (parsed_q.size() > first)
			mark_last();
	endtask

	// predict on accepted bytes, compare accepted results
	always @(posedge clk or negedge arst_n) begin
		dir_result_t w;
		if (!arst_n) begin
			extent_size = '0;
			clear_walk();
			parsed_q.delete();
			fails = 0;
		end else begin
			if (extent_size_we) begin
				extent_size = extent_size_wdata;
				clear_walk();
			end
			if (in_ch.valid && in_ch.ready)
				walk_byte(in_ch.data_byte);
			if (out_ch.valid && out_ch.ready) begin
				if (parsed_q.size() == 0) begin
					if (fails < 10)
						$display("%0t: unexpected result kind %0d char %02h last %0d",
							$realtime, out_ch.kind, out_ch.name_char, out_ch.last);
					fails++;
				end else begin
					w = parsed_q.pop_front();
					if (out_ch.kind !== w.kind || out_ch.name_char !== w.name_char
							|| out_ch.extent_lba !== w.extent_lba
							|| out_ch.file_size !== w.file_size
							|| out_ch.is_dir !== w.is_dir
							|| out_ch.name_len !== w.name_len || out_ch.last !== w.last) begin
						if (fails < 10)
							$display({"%0t: mismatch expected kind %0d char %02h lba %08h ",
								"size %08h dir %0d len %0d last %0d, got kind %0d char %02h ",
								"lba %08h size %08h dir %0d len %0d last %0d"}, $realtime,
								w.kind, w.name_char, w.extent_lba, w.file_size, w.is_dir,
								w.name_len, w.last, out_ch.kind, out_ch.name_char,
								out_ch.extent_lba, out_ch.file_size, out_ch.is_dir,
								out_ch.name_len, out_ch.last);
						fails++;
					end
				end
			end
		end
		fail_count  <= fails;
		outstanding <= parsed_q.size();
	end

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: directory record parser testbench
// Short directed extents first: no extent size, a zero extent, bad records
// and one-byte extents. Then one idle mix each for a semicolon cut with a
// block skip, a dot entry with case edges and trailing blanks, empty and
// oversized identifiers, and a run of random extents.
// The checker beside the block predicts and compares every result item.
// ----------------------------------------------------------------------------
module tb;
	import idr_pkg::*;

	localparam int BLOCK       = 2048;
	localparam int STALL_LIMIT = 4000;
	localparam int PHASE_ITEMS = 20;

	logic        clk;
	logic        arst_n;
	logic        extent_size_we;
	logic [31:0] extent_size_wdata;
	int          fail_count;
	int          outstanding;
	int          idle_pct = 0;
	int          stall_pct = 0;
	int          quiet_cycles = 0;
	int          record_bytes = 0;
	logic [7:0]  ext_bytes[$];
	logic [7:0]  name_buf[$];

	idr_byte_if   in_ch();
	idr_result_if out_ch();

	iso9660_dir_record_parser #(
		.BLOCK_BYTES(BLOCK)
	) u_top (
		.clk              (clk),
		.arst_n           (arst_n),
		.extent_size_we   (extent_size_we),
		.extent_size_wdata(extent_size_wdata),
		.in_ch            (in_ch),
		.out_ch           (out_ch)
	);

	idr_result_checker #(
		.BLOCK_BYTES(BLOCK)
	) u_checker (
		.clk              (clk),
		.arst_n           (arst_n),
		.extent_size_we   (extent_size_we),
		.extent_size_wdata(extent_size_wdata),
		.in_ch            (in_ch),
		.out_ch           (out_ch),
		.fail_count       (fail_count),
		.outstanding      (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// receiver stalls
	always @(posedge clk) begin
		out_ch.ready <= ($urandom_range(99) >= stall_pct);
	end

	// watchdog: cycles with nothing accepted
	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || extent_size_we)
			quiet_cycles <= 0;
		else if (quiet_cycles >= STALL_LIMIT) begin
			$display("tb NOT OK");
			$finish;
		end else
			quiet_cycles <= quiet_cycles + 1;
	end

	// one byte, returns at the edge it is taken
	task automatic send_byte(input logic [7:0] b);
		while ($urandom_range(99) < idle_pct) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid     <= 1'b1;
		in_ch.data_byte <= b;
		do @(posedge clk); while (!in_ch.ready);
	endtask

	// hold the sender until every owed result is out
	task automatic drain_results();
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
	endtask

	task automatic write_extent(input logic [31:0] v);
		drain_results();
		repeat (8) @(posedge clk);
		extent_size_we    <= 1'b1;
		extent_size_wdata <= v;
		@(posedge clk);
		extent_size_we    <= 1'b0;
	endtask

	// rearm with size, then stream ext_bytes; optional drain before byte pause_at
	task automatic stream_extent(input logic [31:0] size, input int pause_at);
		write_extent(size);
		foreach (ext_bytes[i]) begin
			if (i == pause_at)
				drain_results();
			send_byte(ext_bytes[i]);
		end
	endtask

	// append to the extent image and to the name being built
	task automatic put_byte(input logic [7:0] b);
		ext_bytes.insert(ext_bytes.size(), b);
	endtask

	task automatic put_name(input logic [7:0] b);
		name_buf.insert(name_buf.size(), b);
	endtask

	task automatic set_name(input string s);
		name_buf.delete();
		for (int i = 0; i < s.len(); i++)
			put_name(s[i]);
	endtask

	function automatic logic [7:0] name_byte();
		case ($urandom_range(9))
			0, 1, 2: return 8'($urandom_range("Z", "A"));
			3, 4:    return 8'($urandom_range("z", "a"));
			5:       return 8'($urandom_range("9", "0"));
			6:       return ".";
			7:       return CHAR_SEMI;
			8:       return ($urandom_range(1) == 0) ? 8'h20 : 8'($urandom_range(8'h0D, 8'h09));
			default: return 8'($urandom);
		endcase
	endfunction

	task automatic random_name(input int n);
		name_buf.delete();
		repeat (n) put_name(name_byte());
	endtask

	// append one directory record; id_field < 0 takes the real name length
	task automatic add_record(input logic [31:0] lba, input logic [31:0] size,
			input logic [7:0] flags, input int pad, input int id_field);
		int rlen;
		rlen = int'(HDR_LEN) + name_buf.size() + pad;
		put_byte(8'(rlen));
		put_byte(8'($urandom));
		for (int i = 0; i < 4; i++) put_byte(lba[8*i +: 8]);
		for (int i = 3; i >= 0; i--) put_byte(lba[8*i +: 8]);
		for (int i = 0; i < 4; i++) put_byte(size[8*i +: 8]);
		for (int i = 3; i >= 0; i--) put_byte(size[8*i +: 8]);
		repeat (7) put_byte(8'($urandom));
		put_byte(flags);
		repeat (6) put_byte(8'($urandom));
		put_byte((id_field < 0) ? 8'(name_buf.size()) : 8'(id_field));
		foreach (name_buf[i]) put_byte(name_buf[i]);
		repeat (pad) put_byte(8'($urandom));
		record_bytes += rlen;
	endtask

	// mostly good records, some dot entries, oversized ids, skips, bad records
	task automatic build_random_extent(output logic [31:0] size_out);
		int  nrec;
		int  pick;
		int  nlen;
		int  pad;
		bit  done;
		ext_bytes.delete();
		nrec = $urandom_range(2, 1);
		done = 1'b0;
		for (int r = 0; r < nrec && !done; r++) begin
			pick = $urandom_range(99);
			if (pick < 70) begin
				nlen = ($urandom_range(9) == 0) ? $urandom_range(60, 13) : $urandom_range(12, 0);
				random_name(nlen);
				add_record($urandom, $urandom, 8'($urandom), $urandom_range(3), -1);
			end else if (pick < 78) begin
				name_buf.delete();
				put_name(8'($urandom_range(DOT_MAX)));
				add_record($urandom, $urandom, 8'($urandom), $urandom_range(2), -1);
			end else if (pick < 86) begin
				random_name($urandom_range(8));
				pad = $urandom_range(3);
				add_record($urandom, $urandom, 8'($urandom), pad,
					name_buf.size() + pad + $urandom_range(40, 1));
			end else if (pick < 93) begin
				put_byte(8'h00);
				repeat ($urandom_range(20, 3)) put_byte(8'($urandom));
				done = 1'b1;
			end else begin
				put_byte(8'($urandom_range(MIN_REC - 1, 1)));
				repeat ($urandom_range(10, 1)) put_byte(8'($urandom));
				done = 1'b1;
			end
		end
		size_out = ext_bytes.size();
		pick = $urandom_range(9);
		// extent cut short so the last record overruns it
		if (pick == 0 && size_out > 40)
			size_out = size_out - $urandom_range(8, 1);
		// stray bytes past the extent end
		else if (pick == 1)
			repeat ($urandom_range(4, 1)) put_byte(8'($urandom));
	endtask

	initial begin
		logic [31:0] size;
		int          goal;
		in_ch.valid       = 1'b0;
		in_ch.data_byte   = '0;
		extent_size_we    = 1'b0;
		extent_size_wdata = '0;
		arst_n            = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// no extent size yet: bytes give nothing
		repeat (3) send_byte(8'($urandom));

		// zero extent written explicitly
		ext_bytes.delete();
		put_byte(8'h40);
		put_byte(8'h00);
		stream_extent(32'd0, -1);

		// record shorter than the minimum stops the walk
		ext_bytes.delete();
		put_byte(MIN_REC - 8'd1);
		repeat (3) put_byte(8'($urandom));
		stream_extent(32'd100, -1);

		// record running past the extent
		ext_bytes.delete();
		put_byte(8'd50);
		repeat (5) put_byte(8'($urandom));
		stream_extent(32'd40, -1);

		// one-byte extents: skip then end, and a bad length alone
		ext_bytes.delete();
		put_byte(8'h00);
		stream_extent(32'd1, -1);
		ext_bytes.delete();
		put_byte(8'h05);
		put_byte(8'h00);
		stream_extent(32'd1, -1);

		// one extent per idle mix, random extents in the last
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin
					idle_pct  = 0;
					stall_pct = 0;
				end
				1: begin
					idle_pct  = 79;
					stall_pct = 0;
				end
				2: begin
					idle_pct  = 0;
					stall_pct = 79;
				end
				default: begin
					idle_pct  = 27;
					stall_pct = 27;
				end
			endcase
			ext_bytes.delete();
			case (ph)
				0: begin
					// semicolon cut, then a block skip; the largest extent never ends
					set_name("ReadMe.TXT;1;X");
					add_record(32'hFFFF_FFFF, 32'h0, 8'h02, 0, -1);
					put_byte(8'h00);
					repeat (2) put_byte(8'($urandom));
					stream_extent(32'hFFFF_FFFF, -1);
				end
				1: begin
					// dot entry, then case edges and trailing blanks up to the extent end
					name_buf.delete();
					put_name(DOT_MAX);
					add_record(32'h11, 32'h800, 8'h02, 0, -1);
					set_name("@AZ[az{");
					put_name(8'h60);
					put_name(8'hFF);
					put_name(8'h20);
					put_name(8'h0D);
					put_name(8'h09);
					add_record(32'h0, 32'hFFFF_FFFF, 8'hFD, 0, -1);
					stream_extent(ext_bytes.size(), -1);
				end
				2: begin
					// empty identifier, then an identifier length past the record
					name_buf.delete();
					add_record(32'h1234_5678, 32'h9ABC_DEF0, 8'h00, 1, -1);
					set_name("BIG");
					add_record(32'h7, 32'h7, 8'h02, 1, 40);
					stream_extent(ext_bytes.size(), ext_bytes.size() / 2);
				end
				default: begin
					goal = record_bytes + PHASE_ITEMS;
					while (record_bytes < goal) begin
						build_random_extent(size);
						stream_extent(size, -1);
					end
				end
			endcase
		end

		drain_results();
		repeat (20) @(posedge clk);
		if (fail_count == 0 && outstanding == 0)
			$display("tb OK");
		else
			$display("tb NOT OK");
		$finish;
	end

endmodule
